### rtl/core/mf_pkg.sv
// Shared types and constants for the 3x3 median filter.
`timescale 1ns / 1ps

package mf_pkg;

	localparam int unsigned PIX_W       = 8;
	localparam int unsigned WIDTH_REG_W = 11;
	localparam int unsigned HEIGHT_W    = 12;
	localparam int unsigned CFG_DATA_W  = 12;
	localparam int unsigned CFG_IDX_W   = 1;

	localparam int unsigned RESET_WIDTH  = 640;
	localparam int unsigned RESET_HEIGHT = 480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} mf_reg_t;

	typedef logic [PIX_W-1:0] mf_pix_t;

	// One window column: [0] top row, [1] middle row, [2] bottom row.
	typedef logic [2:0][PIX_W-1:0] mf_col_t;

	// Per-beat decisions made when the beat is accepted.
	typedef struct packed {
		logic keep;
		logic is_flush;
		logic emit;
		logic last;
		logic median_en;
		logic col_zero;
		logic edge_upd;
	} mf_flags_t;

	// Refresh of the last-column value after a width change.
	typedef struct packed {
		logic rd;
		logic ld;
	} mf_reload_t;

endpackage

### rtl/core/median_filter_3x3.sv
// 3x3 median filter over a raster stream of 8-bit gray pixels.
// An accepted beat is registered in stage one, and its result is then registered in the
// output register; results trail the input by one row plus one pixel.
// Throughput: one beat per clock unless stalled, set by the store reads issued at acceptance.
// A width write stalls the input while the last-column value is re-read.
// Reset clears counters, window and handshake state; the line stores are not cleared.
`timescale 1ns / 1ps

module median_filter_3x3 import mf_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [PIX_W-1:0]      pixel_in,
	input  logic                  flush,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [PIX_W-1:0]      pixel_out,
	output logic                  frame_end
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);

	logic          accept;
	logic [CW-1:0] col;
	logic [CW-1:0] last_col;
	mf_flags_t     flags;
	mf_reload_t    reload;

	logic          s1_v_q;
	mf_pix_t       pix_s1;
	logic [CW-1:0] col_s1;
	mf_flags_t     flags_s1;
	logic          fwd_s1;
	mf_pix_t       fwd_prev_s1;
	mf_pix_t       fwd_prev2_s1;
	logic          s1_move;

	mf_pix_t       prev_rdata;
	mf_pix_t       prev2_rdata;
	logic          ram_re;
	logic [CW-1:0] ram_raddr;

	mf_col_t       win_q [3];
	mf_pix_t       edge_q;
	mf_pix_t       lp;
	mf_pix_t       lp2;
	mf_pix_t       newp;
	mf_col_t       new_col;
	mf_pix_t       med;
	mf_pix_t       val;

	logic          res_valid_q;
	mf_pix_t       pixel_out_q;
	logic          frame_end_q;

	mf_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.accept  (accept),
		.flush   (flush),
		.col     (col),
		.last_col(last_col),
		.flags   (flags),
		.reload  (reload)
	);

	// A beat that gives no result may leave even while the output is stalled.
	assign s1_move    = s1_v_q && (!flags_s1.emit || !res_valid_q || !result_stall);
	assign item_stall = reload.rd || (s1_v_q && !s1_move);
	assign accept     = item_valid && !item_stall;
	assign ram_re     = accept || reload.rd;
	assign ram_raddr  = reload.rd ? last_col : col;

	mf_ram #(
		.DW   (PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_prev (
		.clk  (clk),
		.we   (s1_move),
		.waddr(col_s1),
		.wdata(newp),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(prev_rdata)
	);

	mf_ram #(
		.DW   (PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_prev2 (
		.clk  (clk),
		.we   (s1_move),
		.waddr(col_s1),
		.wdata(lp),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(prev2_rdata)
	);

	// The store write of the leaving beat and the read of the entering one fall on
	// the same edge; when the columns match, the written values are carried along.
	always_comb begin
		lp         = fwd_s1 ? fwd_prev_s1 : prev_rdata;
		lp2        = fwd_s1 ? fwd_prev2_s1 : prev2_rdata;
		newp       = flags_s1.is_flush ? '0 : pix_s1;
		new_col[0] = lp2;
		new_col[1] = lp;
		new_col[2] = newp;
	end

	mf_median9 u_median (
		.col_a(win_q[1]),
		.col_b(win_q[2]),
		.col_c(new_col),
		.med  (med)
	);

	always_comb begin
		if (flags_s1.col_zero) begin
			val = edge_q;
		end else if (flags_s1.median_en) begin
			val = med;
		end else begin
			val = win_q[2][1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (accept) begin
				s1_v_q <= flags.keep;
				fwd_s1 <= s1_move && (col_s1 == col);
			end else if (s1_move) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= pixel_in;
			col_s1       <= col;
			flags_s1     <= flags;
			fwd_prev_s1  <= newp;
			fwd_prev2_s1 <= lp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
			edge_q   <= '0;
		end else begin
			if (s1_move) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= new_col;
				if (flags_s1.edge_upd) begin
					edge_q <= lp;
				end
			end else if (reload.ld) begin
				edge_q <= prev2_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (s1_move && flags_s1.emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && flags_s1.emit) begin
			pixel_out_q <= val;
			frame_end_q <= flags_s1.last;
		end
	end

	assign result_valid = res_valid_q;
	assign pixel_out    = pixel_out_q;
	assign frame_end    = frame_end_q;

	a_fwd_needs_move: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (!fwd_s1 || $past(s1_move)))
		else $error("store forwarding set without a store write on the same edge");

	a_last_is_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && flags_s1.last) |-> (flags_s1.is_flush && flags_s1.emit))
		else $error("frame end marked on a beat that is not an emitting flush");

	a_width_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (wr_index == REG_WIDTH)) |=> (item_stall && !accept))
		else $error("beat accepted while the last-column value is being re-read");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && flags_s1.emit && res_valid_q && result_stall) |=> s1_v_q)
		else $error("emitting beat left stage one while the output was blocked");

endmodule

### rtl/core/mf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mf_ram #(
	parameter int unsigned DW    = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/mf_median9.sv
// Median of a 3x3 window by sorting columns and combining their ranks.
`timescale 1ns / 1ps

module mf_median9 import mf_pkg::*; (
	input  mf_col_t col_a,
	input  mf_col_t col_b,
	input  mf_col_t col_c,
	output mf_pix_t med
);

	function automatic mf_col_t sort3(input mf_col_t v);
		mf_pix_t a;
		mf_pix_t b;
		mf_pix_t c;
		mf_pix_t t;
		mf_col_t s;
		a = v[0];
		b = v[1];
		c = v[2];
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		if (b > c) begin
			t = b;
			b = c;
			c = t;
		end
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		s[0] = a;
		s[1] = b;
		s[2] = c;
		return s;
	endfunction

	mf_col_t sa, sb, sc;
	mf_col_t lows, mids, highs;
	mf_col_t sl, sm, sh, fin;

	always_comb begin
		sa = sort3(col_a);
		sb = sort3(col_b);
		sc = sort3(col_c);
		lows[0]  = sa[0];
		lows[1]  = sb[0];
		lows[2]  = sc[0];
		mids[0]  = sa[1];
		mids[1]  = sb[1];
		mids[2]  = sc[1];
		highs[0] = sa[2];
		highs[1] = sb[2];
		highs[2] = sc[2];
		sl = sort3(lows);
		sm = sort3(mids);
		sh = sort3(highs);
		// The median is the middle of: largest low, middle mid, smallest high.
		fin[0] = sl[2];
		fin[1] = sm[1];
		fin[2] = sh[0];
		fin = sort3(fin);
		med = fin[1];
	end

endmodule

### rtl/core/mf_ctrl.sv
// Frame position counters, drain control and size registers.
`timescale 1ns / 1ps

module mf_ctrl import mf_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [CFG_IDX_W-1:0]         wr_index,
	input  logic [CFG_DATA_W-1:0]        wr_data,
	input  logic                         accept,
	input  logic                         flush,
	output logic [$clog2(MAX_WIDTH)-1:0] col,
	output logic [$clog2(MAX_WIDTH)-1:0] last_col,
	output mf_flags_t                    flags,
	output mf_reload_t                   reload
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned PW = $clog2(MAX_WIDTH + 2);
	localparam int unsigned XW = WW + 1;
	localparam int unsigned VW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
	localparam int unsigned RW = HEIGHT_W + 1;

	function automatic logic [WW-1:0] clamp_w(input logic [WIDTH_REG_W-1:0] v);
		logic [VW-1:0] ext;
		ext = VW'(v);
		if (ext == '0) begin
			ext = VW'(1);
		end else if (ext > VW'(MAX_WIDTH)) begin
			ext = VW'(MAX_WIDTH);
		end
		return WW'(ext);
	endfunction

	logic [WW-1:0]       w_q;
	logic [HEIGHT_W-1:0] h_q;
	logic [CW-1:0]       col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [PW-1:0]       pend_q;
	logic                reload_rd_q;
	logic                reload_ld_q;

	logic                draining;
	logic                restart;
	logic [CW-1:0]       c;
	logic [HEIGHT_W-1:0] r;
	logic [PW-1:0]       pend;
	logic [XW-1:0]       c1;
	logic [RW-1:0]       r1;
	logic                wrap;
	logic                hwrap;
	logic [WW-1:0]       w_m1;

	always_comb begin
		draining = (pend_q != '0);
		restart  = !flush && draining;
		c        = restart ? '0 : col_q;
		r        = restart ? '0 : row_q;
		pend     = restart ? '0 : pend_q;
		c1       = XW'(c) + XW'(1);
		r1       = RW'(r) + RW'(1);
		wrap     = (c1 >= XW'(w_q));
		hwrap    = (r1 >= RW'(h_q));
		w_m1     = w_q - WW'(1);

		flags.keep     = !(flush && !draining);
		flags.is_flush = flush;
		flags.last     = flush && (pend == PW'(1));
		if (flush) begin
			flags.emit = (h_q >= HEIGHT_W'(2)) || (pend <= PW'(w_q));
		end else begin
			flags.emit = (r >= HEIGHT_W'(2)) || ((r == HEIGHT_W'(1)) && (c != '0));
		end
		flags.median_en = !flush && (XW'(c) >= XW'(3)) && (XW'(c) + XW'(2) <= XW'(w_q))
			&& (r >= HEIGHT_W'(3)) && (RW'(r) + RW'(2) <= RW'(h_q));
		flags.col_zero = (c == '0);
		flags.edge_upd = (c1 == XW'(w_q));

		col      = c;
		last_col = w_m1[CW-1:0];
		reload.rd = reload_rd_q;
		reload.ld = reload_ld_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= clamp_w(WIDTH_REG_W'(RESET_WIDTH));
			h_q         <= HEIGHT_W'(RESET_HEIGHT);
			col_q       <= '0;
			row_q       <= '0;
			pend_q      <= '0;
			reload_rd_q <= 1'b0;
			reload_ld_q <= 1'b0;
		end else begin
			reload_rd_q <= 1'b0;
			reload_ld_q <= reload_rd_q;
			if (wr_en) begin
				case (wr_index)
					REG_WIDTH: begin
						w_q         <= clamp_w(wr_data[WIDTH_REG_W-1:0]);
						reload_rd_q <= 1'b1;
					end
					REG_HEIGHT: begin
						h_q <= (wr_data[HEIGHT_W-1:0] == '0) ? HEIGHT_W'(1)
							: wr_data[HEIGHT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (accept && flags.keep) begin
				if (flush) begin
					pend_q <= pend - PW'(1);
					col_q  <= (wrap || flags.last) ? '0 : c1[CW-1:0];
				end else if (wrap) begin
					col_q <= '0;
					if (hwrap) begin
						row_q  <= '0;
						pend_q <= PW'(w_q) + PW'(1);
					end else begin
						row_q  <= r1[HEIGHT_W-1:0];
						pend_q <= pend;
					end
				end else begin
					col_q  <= c1[CW-1:0];
					row_q  <= r;
					pend_q <= pend;
				end
			end
		end
	end

endmodule
